FILE: sv/rbt_pkg.sv
// ----------------------------------------------------------------------------
// rbt_pkg: shared types and constants of the raster boundary tracer
// Raster size, field widths, request and status codes, heading codes.
// ----------------------------------------------------------------------------
package rbt_pkg;

  // Largest raster side that the cell store holds.
  localparam int MAX_SIDE   = 256;
  localparam int ROW_AW     = $clog2(MAX_SIDE);
  localparam int SIDE_W     = $clog2(MAX_SIDE + 1);

  // Field widths fixed by the interface.
  localparam int CELL_W     = 8;
  localparam int CFG_SIDE_W = 9;
  localparam int COORD_W    = 20;
  localparam int STATUS_W   = 3;
  localparam int OPCODE_W   = 2;
  localparam int IN_W       = 24;
  localparam int OUT_W      = 2 * COORD_W;

  localparam int PROD_W     = COORD_W + SIDE_W;
  localparam int LIMIT_W    = $clog2(4 * (MAX_SIDE + 1) * (MAX_SIDE + 1) + 1);

  localparam logic [COORD_W-1:0]    COORD_LIMIT = COORD_W'(1000000);
  localparam logic [COORD_W-1:0]    COORD_RESET = COORD_W'(100000);
  localparam logic [CFG_SIDE_W-1:0] SIDE_RESET  = CFG_SIDE_W'(192);

  // Configuration register indexes.
  localparam int CFG_AW = 1;
  localparam logic [CFG_AW-1:0] CFG_GRID_SIDE = 1'b0;
  localparam logic [CFG_AW-1:0] CFG_COORD_MAX = 1'b1;

  typedef enum logic [OPCODE_W-1:0] {
    OP_WRITE   = 2'd0,
    OP_START   = 2'd1,
    OP_ADVANCE = 2'd2
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK          = 3'd0,
    ST_EMPTY       = 3'd1,
    ST_DEAD_END    = 3'd2,
    ST_NOT_TRACING = 3'd3,
    ST_STEP_LIMIT  = 3'd4
  } status_t;

  // Heading codes.
  localparam logic [1:0] DIR_PX = 2'd0;
  localparam logic [1:0] DIR_NY = 2'd1;
  localparam logic [1:0] DIR_NX = 2'd2;
  localparam logic [1:0] DIR_PY = 2'd3;

endpackage

FILE: sv/raster_boundary_tracer_unit.sv
// ----------------------------------------------------------------------------
// raster_boundary_tracer_unit: square-tracing outline follower
// Loads a one-bit cell raster and walks the outline of its occupied nodes.
// ----------------------------------------------------------------------------
// Requests arrive on the in_ stream; in_tuser carries the opcode (write cell,
// start trace, advance trace). A write produces no result; start and advance
// produce one result on the out_ stream: scaled vertex in out_tdata, status in
// out_tuser and out_tlast set when the trace has closed on its origin.
// The cells live in one RAM of MAX_SIDE rows, one row per x column, each row
// read whole; a row is only valid once it has been written.
// A write is a read-modify-write of its row.
// An advance reads four rows around the current node one after another,
// picks the move, then two scalers divide by the side one bit a cycle.
// A start scans columns one after another until one holds an occupied
// node, searches that column 16 bits a cycle, then scales as above.
// Every result with a vertex passes through the scalers; the rest skip them.
// Reset clears the row valid flags at once, so the raster reads empty with no
// clearing pass, and sets grid_side to 192 and coord_max to 100000.
// The result sits in an output register: while the receiver stalls the unit
// still takes and finishes the next request, and holds only before it has a
// second result to deliver.
// ----------------------------------------------------------------------------
module raster_boundary_tracer_unit (
  input  logic                          clk,
  input  logic                          rst_n,
  // in_tdata: cell_x[7:0], cell_y[15:8], cell_fill[16], zero[23:17]
  input  logic [rbt_pkg::IN_W-1:0]      in_tdata,
  // in_tuser: opcode[1:0]
  input  logic [rbt_pkg::OPCODE_W-1:0]  in_tuser,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  // out_tdata: vertex_x[19:0], vertex_y[39:20]
  output logic [rbt_pkg::OUT_W-1:0]     out_tdata,
  // out_tuser: status[2:0]
  output logic [rbt_pkg::STATUS_W-1:0]  out_tuser,
  output logic                          out_tlast,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  input  logic                          cfg_we,
  input  logic [rbt_pkg::CFG_AW-1:0]    cfg_addr,
  input  logic [rbt_pkg::COORD_W-1:0]   cfg_wdata
);
  import rbt_pkg::*;

  localparam int CHUNK_W  = 16;
  localparam int CHUNK_BW = $clog2(CHUNK_W);
  localparam int NCHUNK   = (MAX_SIDE + CHUNK_W - 1) / CHUNK_W;
  localparam int CHUNK_CW = (NCHUNK > 1) ? $clog2(NCHUNK) : 1;
  localparam int SCAN_W   = NCHUNK * CHUNK_W;
  localparam int Q_W      = SIDE_W + 1;

  typedef enum logic [3:0] {
    S_IDLE, S_WR_MOD, S_SC_RD, S_SC_CAP, S_SC_FIND, S_ST_CHK, S_ST_RD,
    S_ST_CAP, S_ST_EVAL, S_SCALE, S_SCALE_WAIT, S_OUT
  } state_t;

  state_t                state_r;

  logic [CFG_SIDE_W-1:0] grid_side_r;
  logic [COORD_W-1:0]    coord_max_r;
  logic [LIMIT_W-1:0]    limit_r;

  logic [MAX_SIDE-1:0]   row_valid_r;
  logic [ROW_AW-1:0]     wr_row_r;
  logic [ROW_AW-1:0]     wr_col_r;
  logic                  wr_fill_r;
  logic                  wr_ok_r;

  logic [SIDE_W-1:0]     scan_i_r;
  logic [MAX_SIDE-1:0]   prev_r;
  logic [SCAN_W-1:0]     m_r;
  logic [CHUNK_CW-1:0]   chunk_r;
  logic                  row_ok_r;
  logic [15:0]           win_r;
  logic [1:0]            win_a_r;

  logic [SIDE_W-1:0]     pos_x_r;
  logic [SIDE_W-1:0]     pos_y_r;
  logic [SIDE_W-1:0]     origin_x_r;
  logic [SIDE_W-1:0]     origin_y_r;
  logic [1:0]            heading_r;
  logic                  tracing_r;
  logic [LIMIT_W-1:0]    step_r;

  status_t               res_status_r;
  logic                  res_closed_r;
  logic                  res_pos_r;

  logic                  out_tvalid_r;
  logic [OUT_W-1:0]      out_tdata_r;
  logic [STATUS_W-1:0]   out_tuser_r;
  logic                  out_tlast_r;
  logic                  out_load;

  // Derived configuration and RAM port signals.
  logic [SIDE_W-1:0]     side_u;
  logic [COORD_W-1:0]    coord_u;
  logic [2*Q_W+1:0]      limit_full;
  logic [MAX_SIDE-1:0]   col_mask;
  logic [MAX_SIDE-1:0]   rdata;
  logic [MAX_SIDE-1:0]   row_wdata;
  logic                  ram_we;
  logic [ROW_AW-1:0]     ram_raddr;

  logic                  in_fire;
  logic [ROW_AW-1:0]     in_row;

  logic [MAX_SIDE-1:0]   scan_cur;
  logic [MAX_SIDE-1:0]   scan_col;
  logic [CHUNK_W-1:0]    chunk_bits;
  logic [SIDE_W-1:0]     found_y;

  logic [Q_W-1:0]        st_qr;
  logic                  st_row_ok;
  logic [3:0]            st_bits;

  logic [3:0]            occ;
  logic [1:0]            cand [3];
  logic                  move_ok;
  logic [1:0]            move_dir;
  logic [SIDE_W-1:0]     move_x;
  logic [SIDE_W-1:0]     move_y;

  logic                  scale_start;
  logic                  busy_x;
  logic                  busy_y;
  logic [COORD_W-1:0]    quot_x;
  logic [COORD_W-1:0]    quot_y;

  function automatic logic [CHUNK_BW-1:0] low_bit(input logic [CHUNK_W-1:0] v);
    logic [CHUNK_BW-1:0] p;
    p = '0;
    for (int k = CHUNK_W - 1; k >= 0; k--) begin
      if (v[k]) begin
        p = CHUNK_BW'(k);
      end
    end
    return p;
  endfunction

  always_comb begin
    if (grid_side_r == '0) begin
      side_u = SIDE_W'(1);
    end else if (32'(grid_side_r) > MAX_SIDE) begin
      side_u = SIDE_W'(MAX_SIDE);
    end else begin
      side_u = SIDE_W'(grid_side_r);
    end
    coord_u    = (coord_max_r > COORD_LIMIT) ? COORD_LIMIT : coord_max_r;
    limit_full = {(2*Q_W)'(Q_W'(side_u) + Q_W'(1)) *
                  (2*Q_W)'(Q_W'(side_u) + Q_W'(1)), 2'b00};
    for (int k = 0; k < MAX_SIDE; k++) begin
      col_mask[k] = 32'(k) < 32'(side_u);
    end
  end

  assign in_tready = (state_r == S_IDLE);
  assign in_fire   = in_tvalid && in_tready;
  assign in_row    = ROW_AW'(in_tdata[CELL_W-1:0]);

  // Column scan: a node column x is occupied where row x-1 or row x holds a cell.
  always_comb begin
    scan_cur   = row_ok_r ? (rdata & col_mask) : '0;
    scan_col   = prev_r | scan_cur;
    chunk_bits = m_r[chunk_r * CHUNK_W +: CHUNK_W];
    found_y    = SIDE_W'({chunk_r, low_bit(chunk_bits)});
  end

  // Step window: rows pos_x-2 .. pos_x+1, columns pos_y-2 .. pos_y+1.
  always_comb begin
    logic [Q_W-1:0] qc;
    st_qr     = Q_W'(pos_x_r) + Q_W'(win_a_r);
    st_row_ok = (st_qr >= Q_W'(2)) && (st_qr < Q_W'(side_u) + Q_W'(2)) &&
                row_valid_r[ROW_AW'(st_qr - Q_W'(2))];
    for (int b = 0; b < 4; b++) begin
      qc         = Q_W'(pos_y_r) + Q_W'(b);
      st_bits[b] = row_ok_r && (qc >= Q_W'(2)) &&
                   (qc < Q_W'(side_u) + Q_W'(2)) && rdata[ROW_AW'(qc - Q_W'(2))];
    end
  end

  // Occupancy of the four neighbour nodes, then left, straight, right.
  always_comb begin
    occ[DIR_PX] = win_r[9] | win_r[10] | win_r[13] | win_r[14];
    occ[DIR_NY] = win_r[4] | win_r[5]  | win_r[8]  | win_r[9];
    occ[DIR_NX] = win_r[1] | win_r[2]  | win_r[5]  | win_r[6];
    occ[DIR_PY] = win_r[6] | win_r[7]  | win_r[10] | win_r[11];
    cand[0]  = heading_r + 2'd3;
    cand[1]  = heading_r;
    cand[2]  = heading_r + 2'd1;
    move_ok  = 1'b0;
    move_dir = heading_r;
    for (int k = 2; k >= 0; k--) begin
      if (occ[cand[k]]) begin
        move_ok  = 1'b1;
        move_dir = cand[k];
      end
    end
    move_x = pos_x_r;
    move_y = pos_y_r;
    case (move_dir)
      DIR_PX:  move_x = pos_x_r + SIDE_W'(1);
      DIR_NY:  move_y = pos_y_r - SIDE_W'(1);
      DIR_NX:  move_x = pos_x_r - SIDE_W'(1);
      DIR_PY:  move_y = pos_y_r + SIDE_W'(1);
      default: move_x = pos_x_r;
    endcase
  end

  always_comb begin
    ram_raddr = in_row;
    case (state_r)
      S_SC_RD: ram_raddr = ROW_AW'(scan_i_r);
      S_ST_RD: ram_raddr = ROW_AW'(st_qr - Q_W'(2));
      default: ram_raddr = in_row;
    endcase
    ram_we    = (state_r == S_WR_MOD) && wr_ok_r;
    row_wdata = row_valid_r[wr_row_r] ? rdata : '0;
    row_wdata[wr_col_r] = wr_fill_r;
  end

  assign scale_start = (state_r == S_SCALE);
  assign out_load    = (state_r == S_OUT) && (!out_tvalid_r || out_tready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      grid_side_r  <= SIDE_RESET;
      coord_max_r  <= COORD_RESET;
      row_valid_r  <= '0;
      pos_x_r      <= '0;
      pos_y_r      <= '0;
      origin_x_r   <= '0;
      origin_y_r   <= '0;
      heading_r    <= DIR_PX;
      tracing_r    <= 1'b0;
      step_r       <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      limit_r <= LIMIT_W'(limit_full);

      if (cfg_we) begin
        case (cfg_addr)
          CFG_GRID_SIDE: grid_side_r <= CFG_SIDE_W'(cfg_wdata);
          CFG_COORD_MAX: coord_max_r <= cfg_wdata;
          default:       coord_max_r <= coord_max_r;
        endcase
      end

      if (out_load) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tvalid_r && out_tready) begin
        out_tvalid_r <= 1'b0;
      end

      case (state_r)
        S_IDLE: begin
          if (in_fire) begin
            case (op_t'(in_tuser))
              OP_WRITE: begin
                wr_row_r  <= in_row;
                wr_col_r  <= ROW_AW'(in_tdata[2*CELL_W-1:CELL_W]);
                wr_fill_r <= in_tdata[2*CELL_W];
                wr_ok_r   <= (32'(in_tdata[CELL_W-1:0]) < MAX_SIDE) &&
                             (32'(in_tdata[2*CELL_W-1:CELL_W]) < MAX_SIDE);
                state_r   <= S_WR_MOD;
              end
              OP_START: begin
                tracing_r <= 1'b0;
                step_r    <= '0;
                heading_r <= DIR_PX;
                scan_i_r  <= '0;
                prev_r    <= '0;
                state_r   <= S_SC_RD;
              end
              OP_ADVANCE: begin
                if (!tracing_r) begin
                  res_status_r <= ST_NOT_TRACING;
                  res_closed_r <= 1'b0;
                  res_pos_r    <= 1'b0;
                  state_r      <= S_OUT;
                end else begin
                  state_r <= S_ST_CHK;
                end
              end
              default: state_r <= S_IDLE;
            endcase
          end
        end

        S_WR_MOD: begin
          if (wr_ok_r) begin
            row_valid_r[wr_row_r] <= 1'b1;
          end
          state_r <= S_IDLE;
        end

        S_SC_RD: begin
          row_ok_r <= (scan_i_r < side_u) && row_valid_r[ROW_AW'(scan_i_r)];
          state_r  <= S_SC_CAP;
        end

        S_SC_CAP: begin
          if (|scan_col) begin
            m_r     <= SCAN_W'(scan_col);
            chunk_r <= '0;
            state_r <= S_SC_FIND;
          end else begin
            prev_r <= scan_cur;
            if (scan_i_r == side_u) begin
              res_status_r <= ST_EMPTY;
              res_closed_r <= 1'b0;
              res_pos_r    <= 1'b0;
              state_r      <= S_OUT;
            end else begin
              scan_i_r <= scan_i_r + SIDE_W'(1);
              state_r  <= S_SC_RD;
            end
          end
        end

        S_SC_FIND: begin
          if (|chunk_bits) begin
            pos_x_r      <= scan_i_r;
            origin_x_r   <= scan_i_r;
            pos_y_r      <= found_y;
            origin_y_r   <= found_y;
            tracing_r    <= 1'b1;
            res_status_r <= ST_OK;
            res_closed_r <= 1'b0;
            res_pos_r    <= 1'b1;
            state_r      <= S_SCALE;
          end else begin
            chunk_r <= chunk_r + CHUNK_CW'(1);
          end
        end

        S_ST_CHK: begin
          if (step_r >= limit_r) begin
            tracing_r    <= 1'b0;
            res_status_r <= ST_STEP_LIMIT;
            res_closed_r <= 1'b0;
            res_pos_r    <= 1'b1;
            state_r      <= S_SCALE;
          end else begin
            win_a_r <= 2'd0;
            state_r <= S_ST_RD;
          end
        end

        S_ST_RD: begin
          row_ok_r <= st_row_ok;
          state_r  <= S_ST_CAP;
        end

        S_ST_CAP: begin
          for (int b = 0; b < 4; b++) begin
            win_r[{win_a_r, 2'(b)}] <= st_bits[b];
          end
          if (win_a_r == 2'd3) begin
            state_r <= S_ST_EVAL;
          end else begin
            win_a_r <= win_a_r + 2'd1;
            state_r <= S_ST_RD;
          end
        end

        S_ST_EVAL: begin
          res_pos_r <= 1'b1;
          if (move_ok) begin
            heading_r    <= move_dir;
            pos_x_r      <= move_x;
            pos_y_r      <= move_y;
            step_r       <= step_r + LIMIT_W'(1);
            res_status_r <= ST_OK;
            res_closed_r <= (move_x == origin_x_r) && (move_y == origin_y_r);
            if ((move_x == origin_x_r) && (move_y == origin_y_r)) begin
              tracing_r <= 1'b0;
            end
          end else begin
            tracing_r    <= 1'b0;
            res_status_r <= ST_DEAD_END;
            res_closed_r <= 1'b0;
          end
          state_r <= S_SCALE;
        end

        S_SCALE: begin
          state_r <= S_SCALE_WAIT;
        end

        S_SCALE_WAIT: begin
          if (!busy_x && !busy_y) begin
            state_r <= S_OUT;
          end
        end

        S_OUT: begin
          if (out_load) begin
            out_tdata_r  <= res_pos_r ? {quot_y, quot_x} : '0;
            out_tuser_r  <= res_status_r;
            out_tlast_r  <= res_closed_r;
            state_r      <= S_IDLE;
          end
        end

        default: state_r <= S_IDLE;
      endcase
    end
  end

  rbt_ram #(
    .WIDTH (MAX_SIDE),
    .DEPTH (MAX_SIDE)
  ) u_cell_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (wr_row_r),
    .wdata (row_wdata),
    .raddr (ram_raddr),
    .rdata (rdata)
  );

  rbt_scale u_scale_x (
    .clk   (clk),
    .rst_n (rst_n),
    .start (scale_start),
    .coord (coord_u),
    .idx   (pos_x_r),
    .side  (side_u),
    .busy  (busy_x),
    .quot  (quot_x)
  );

  rbt_scale u_scale_y (
    .clk   (clk),
    .rst_n (rst_n),
    .start (scale_start),
    .coord (coord_u),
    .idx   (pos_y_r),
    .side  (side_u),
    .busy  (busy_y),
    .quot  (quot_y)
  );

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;
  assign out_tlast  = out_tlast_r;

endmodule

FILE: sv/rbt_ram.sv
// ----------------------------------------------------------------------------
// rbt_ram: generic synchronous RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module rbt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

FILE: sv/rbt_scale.sv
// ----------------------------------------------------------------------------
// rbt_scale: coordinate scaler
// Computes floor(coord * idx / side), saturated at coord, by one multiply
// and a restoring division that yields one quotient bit per cycle.
// ----------------------------------------------------------------------------
module rbt_scale (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [rbt_pkg::COORD_W-1:0]  coord,
  input  logic [rbt_pkg::SIDE_W-1:0]   idx,
  input  logic [rbt_pkg::SIDE_W-1:0]   side,
  output logic                         busy,
  output logic [rbt_pkg::COORD_W-1:0]  quot
);
  import rbt_pkg::*;

  localparam int CNT_W = $clog2(COORD_W);

  logic               busy_r;
  logic               load_r;
  logic [CNT_W-1:0]   cnt_r;
  logic [PROD_W-1:0]  prod_r;
  logic [SIDE_W-1:0]  rem_r;
  logic [COORD_W-1:0] quot_r;
  logic [COORD_W-1:0] coord_r;
  logic [SIDE_W-1:0]  side_r;
  logic               sat_r;

  logic [SIDE_W:0]    trial;
  logic               fits;

  always_comb begin
    trial = {rem_r, quot_r[COORD_W-1]};
    fits  = trial >= {1'b0, side_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      load_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      load_r <= 1'b1;
      cnt_r  <= '0;
    end else if (load_r) begin
      load_r <= 1'b0;
    end else if (busy_r) begin
      cnt_r <= cnt_r + CNT_W'(1);
      if (cnt_r == CNT_W'(COORD_W - 1)) begin
        busy_r <= 1'b0;
      end
    end
  end

  // When idx is below side the quotient stays below coord, so the top bits
  // of the product are already smaller than the divisor.
  always_ff @(posedge clk) begin
    if (start) begin
      prod_r  <= PROD_W'(coord) * PROD_W'(idx);
      sat_r   <= idx >= side;
      coord_r <= coord;
      side_r  <= side;
    end else if (load_r) begin
      rem_r  <= prod_r[PROD_W-1:COORD_W];
      quot_r <= prod_r[COORD_W-1:0];
    end else if (busy_r) begin
      rem_r  <= fits ? SIDE_W'(trial - {1'b0, side_r}) : trial[SIDE_W-1:0];
      quot_r <= {quot_r[COORD_W-2:0], fits};
    end
  end

  assign busy = busy_r;
  assign quot = sat_r ? coord_r : quot_r;

endmodule
